/* rtl/core/herr_pkg.sv */
// Shared constants, codes and helpers for the heap extension range registry.
package herr_pkg;

  // Page granularity of granted blocks
  localparam int unsigned PAGE_BYTES = 4096;
  localparam logic [32:0] PAGE_MASK = 33'(PAGE_BYTES - 1);

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_BUDGET    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BLOCK = 8'd1;

  localparam logic [31:0] BUDGET_RESET    = 32'd268435456;
  localparam logic [31:0] MIN_BLOCK_RESET = 32'd4194304;

  // Address class codes
  localparam logic [1:0] CLS_NONE     = 2'd0;
  localparam logic [1:0] CLS_BASE     = 2'd1;
  localparam logic [1:0] CLS_INTERIOR = 2'd2;

  // Grant status codes
  localparam logic [1:0] GST_PASS    = 2'd0;
  localparam logic [1:0] GST_GRANTED = 2'd1;
  localparam logic [1:0] GST_DENIED  = 2'd2;

  // Payload widths on the stream ports
  localparam int unsigned IN_TDATA_W  = 168;
  localparam int unsigned OUT_TDATA_W = 208;

  // Raise to the minimum block, then round up to whole pages (33 bits, no wrap)
  function automatic logic [32:0] round_block(input logic [31:0] raw,
                                              input logic [31:0] min_blk);
    logic [31:0] blk;
    logic [32:0] sum;
    blk = (raw < min_blk) ? min_blk : raw;
    sum = {1'b0, blk} + PAGE_MASK;
    return sum & ~PAGE_MASK;
  endfunction

endpackage

/* rtl/core/heap_extension_range_registry.sv */
// Top level: range table in RAM, scan sequencer, grant logic and counters.
// Classify reads the used entries in order, one RAM read per cycle, and stops at the first
//   hit; a zero address or an empty table goes straight to the result. Extension rounds
//   the block, then decides and appends; passthrough goes straight to the result.
// One transaction at a time; the result register frees the input while a result waits,
//   and a new result waits in the done state until the result register is free.
// Reset clears counters, config to defaults and control; table RAM is not cleared.
module heap_extension_range_registry #(
  parameter int unsigned MAX_RANGES = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [63:0] query_address, [95:64] request_bytes, [96] primary_failed,
  // [160:97] pool_address, [167:161] zero
  input  logic [herr_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // [0] action
  input  logic                               s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [1:0] address_class, [3:2] grant_status, [67:4] granted_base,
  // [99:68] granted_size, [131:100] extension_total, [163:132] bytes_total,
  // [195:164] denied_total, [202:196] ranges_used, [207:203] zero
  output logic [herr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [herr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [31:0]                        cfg_data_i
);

  localparam int unsigned AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned CW = $clog2(MAX_RANGES + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_EXT1 = 3'd2;
  localparam logic [2:0] ST_EXT2 = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [31:0] budget_q, budget_d, min_blk_q, min_blk_d;
  logic [CW-1:0] used_q, used_d;
  logic [31:0] gcount_q, gcount_d, gbytes_q, gbytes_d, dcount_q, dcount_d;
  logic [CW-1:0] idx_q, idx_d;
  logic        pend_q, pend_d;
  logic [63:0] addr_q, addr_d, pool_q, pool_d;
  logic [31:0] raw_q, raw_d;
  logic [32:0] block_q, block_d;
  logic [1:0]  cls_q, cls_d, status_q, status_d;
  logic [63:0] gbase_q, gbase_d;
  logic [31:0] gsize_q, gsize_d;
  logic        out_valid_q, out_valid_d;
  logic [herr_pkg::OUT_TDATA_W-1:0] out_data_q, out_data_d;

  logic        in_fire, action, primary_failed, positive, deny;
  logic [63:0] in_addr, in_pool;
  logic [31:0] in_raw, headroom;
  logic [6:0]  used_low;
  logic        ram_we;
  logic [95:0] ram_rdata;
  logic        hit;
  logic [1:0]  hit_cls;

  assign in_addr        = s_axis_tdata_i[63:0];
  assign in_raw         = s_axis_tdata_i[95:64];
  assign primary_failed = s_axis_tdata_i[96];
  assign in_pool        = s_axis_tdata_i[160:97];
  assign action         = s_axis_tuser_i;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign positive        = (in_raw != 32'd0) && !in_raw[31];
  assign cfg_ready_o     = 1'b1;

  assign headroom = budget_q - gbytes_q;
  assign deny = (gbytes_q >= budget_q) || (block_q > {1'b0, headroom}) ||
                (used_q >= CW'(MAX_RANGES)) || (pool_q == 64'd0);
  assign ram_we = (state_q == ST_EXT2) && !deny;

  herr_ram #(
    .WIDTH(96),
    .DEPTH(MAX_RANGES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(used_q[AW-1:0]),
    .wdata_i({block_q[31:0], pool_q}),
    .raddr_i(idx_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  herr_scan u_scan (
    .base_i(ram_rdata[63:0]),
    .size_i(ram_rdata[95:64]),
    .addr_i(addr_q),
    .hit_o (hit),
    .cls_o (hit_cls)
  );

  assign used_low = 7'(used_q);

  always_comb begin
    state_d     = state_q;
    budget_d    = budget_q;
    min_blk_d   = min_blk_q;
    used_d      = used_q;
    gcount_d    = gcount_q;
    gbytes_d    = gbytes_q;
    dcount_d    = dcount_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    addr_d      = addr_q;
    pool_d      = pool_q;
    raw_d       = raw_q;
    block_d     = block_q;
    cls_d       = cls_q;
    status_d    = status_q;
    gbase_d     = gbase_q;
    gsize_d     = gsize_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (cfg_valid_i) begin
      if (cfg_index_i == herr_pkg::CFG_BUDGET) begin
        budget_d = cfg_data_i;
      end else if (cfg_index_i == herr_pkg::CFG_MIN_BLOCK) begin
        min_blk_d = cfg_data_i;
      end
    end

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          addr_d   = in_addr;
          raw_d    = in_raw;
          pool_d   = in_pool;
          cls_d    = herr_pkg::CLS_NONE;
          status_d = herr_pkg::GST_PASS;
          gbase_d  = 64'd0;
          gsize_d  = 32'd0;
          idx_d    = '0;
          pend_d   = 1'b0;
          if (!action) begin
            state_d = ((in_addr == 64'd0) || (used_q == '0)) ? ST_DONE : ST_SCAN;
          end else if (primary_failed && positive) begin
            state_d = ST_EXT1;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        // read data of entry idx_q-1 arrives while entry idx_q is addressed
        if (pend_q && hit) begin
          cls_d   = hit_cls;
          state_d = ST_DONE;
        end else if (idx_q == used_q) begin
          state_d = ST_DONE;
        end else begin
          idx_d  = idx_q + CW'(1);
          pend_d = 1'b1;
        end
      end
      ST_EXT1: begin
        block_d = herr_pkg::round_block(raw_q, min_blk_q);
        state_d = ST_EXT2;
      end
      ST_EXT2: begin
        gsize_d = block_q[31:0];
        if (deny) begin
          dcount_d = dcount_q + 32'd1;
          status_d = herr_pkg::GST_DENIED;
        end else begin
          used_d   = used_q + CW'(1);
          gcount_d = gcount_q + 32'd1;
          gbytes_d = gbytes_q + block_q[31:0];
          status_d = herr_pkg::GST_GRANTED;
          gbase_d  = pool_q;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = {5'd0, used_low, dcount_q, gbytes_q, gcount_q,
                         gsize_q, gbase_q, status_q, cls_q};
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      budget_q    <= herr_pkg::BUDGET_RESET;
      min_blk_q   <= herr_pkg::MIN_BLOCK_RESET;
      used_q      <= '0;
      gcount_q    <= 32'd0;
      gbytes_q    <= 32'd0;
      dcount_q    <= 32'd0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      budget_q    <= budget_d;
      min_blk_q   <= min_blk_d;
      used_q      <= used_d;
      gcount_q    <= gcount_d;
      gbytes_q    <= gbytes_d;
      dcount_q    <= dcount_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    pool_q     <= pool_d;
    raw_q      <= raw_d;
    block_q    <= block_d;
    cls_q      <= cls_d;
    status_q   <= status_d;
    gbase_q    <= gbase_d;
    gsize_q    <= gsize_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

/* rtl/core/herr_ram.sv */
// Generic simple dual-port RAM, one write port, one registered read port.
module herr_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/herr_scan.sv */
// Range check of one stored entry against the query address.
module herr_scan (
  input  logic [63:0] base_i,
  input  logic [31:0] size_i,
  input  logic [63:0] addr_i,
  output logic        hit_o,
  output logic [1:0]  cls_o
);

  logic [64:0] end_full;
  logic        usable;

  // entries with zero base, zero size or an end at or past 2^64 never match
  assign end_full = {1'b0, base_i} + {33'd0, size_i};
  assign usable   = (base_i != 64'd0) && (size_i != 32'd0) && !end_full[64];
  assign hit_o    = usable && (addr_i >= base_i) && (addr_i < end_full[63:0]);
  assign cls_o    = (addr_i == base_i) ? herr_pkg::CLS_BASE : herr_pkg::CLS_INTERIOR;

endmodule
